### src/canrxq_pkg.sv
// ----------------------------------------------------------------------------
// CAN receive frame queue package
// Shared types and constants for the receive frame queue.
// ----------------------------------------------------------------------------
package canrxq_pkg;

    localparam int ID_W       = 29;
    localparam int DLC_W      = 4;
    localparam int WORD_W     = 32;
    localparam int PAYLOAD_W  = 2 * WORD_W;
    localparam int EXT_BIT    = 31;
    localparam int STD_ID_LSB = 18;
    localparam int STD_ID_MSB = 28;
    localparam int RTR_BIT    = 4;

    localparam logic [DLC_W-1:0] MAX_DLC     = 4'd8;
    localparam logic [DLC_W-1:0] LOW_MIN_DLC = 4'd4;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_PUSH_STORED  = 2'd0,
        STAT_PUSH_DROPPED = 2'd1,
        STAT_POP_DELIVERED = 2'd2,
        STAT_POP_EMPTY    = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_FETCH
    } state_t;

    typedef struct packed {
        logic              opcode;
        logic [WORD_W-1:0] desc_word0;
        logic [WORD_W-1:0] desc_word1;
        logic [WORD_W-1:0] desc_data_high;
        logic [WORD_W-1:0] desc_data_low;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   frame_id;
        logic              frame_extended;
        logic              frame_rtr;
        logic [DLC_W-1:0]  frame_dlc;
        logic [WORD_W-1:0] frame_data_high;
        logic [WORD_W-1:0] frame_data_low;
        logic [3:0]        pending_count;
    } res_t;

    typedef struct packed {
        logic [DLC_W-1:0] dlc;
        logic             rtr;
        logic             ext;
        logic [ID_W-1:0]  id;
    } header_t;

    localparam int HEADER_W = $bits(header_t);

    typedef struct packed {
        logic    store;
        logic    fetch;
        logic    load_imm;
        status_t imm_status;
        logic    load_pop;
    } ctrl_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } dp_status_t;

endpackage

### src/can_rx_descriptor_frame_queue_core.sv
// ----------------------------------------------------------------------------
// CAN receive descriptor frame queue
// Decodes receive descriptors into frames and queues them in a ring buffer.
// ----------------------------------------------------------------------------
// A push transaction decodes one descriptor and stores the frame, or drops it
// when the ring holds QUEUE_DEPTH-1 frames; a pop returns the oldest frame or
// an empty status. Every transaction gives one result with the pending count.
// A push or empty pop loads the result directly; a delivering pop reads the
// registered port of the frame RAMs and loads the result in the fetch state
// once the output is free. A new transaction is taken in the cycle the
// previous result is taken. Frame stores need no clearing after reset.
module can_rx_descriptor_frame_queue_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  canrxq_pkg::cmd_t cmd,
    output logic             res_valid,
    input  logic             res_stall,
    output canrxq_pkg::res_t res
);
    import canrxq_pkg::*;

    ctrl_cmd_t  ctrl;
    dp_status_t stat;

    canrxq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .opcode    (cmd.opcode),
        .res_stall (res_stall),
        .stat      (stat),
        .cmd_stall (cmd_stall),
        .res_valid (res_valid),
        .ctrl      (ctrl)
    );

    canrxq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .ctrl  (ctrl),
        .stat  (stat),
        .res   (res)
    );

endmodule

### src/canrxq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module canrxq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/canrxq_datapath.sv
// ----------------------------------------------------------------------------
// CAN receive frame queue datapath
// Descriptor decode, ring pointers, frame stores and result register.
// ----------------------------------------------------------------------------
module canrxq_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  canrxq_pkg::cmd_t       cmd,
    input  canrxq_pkg::ctrl_cmd_t  ctrl,
    output canrxq_pkg::dp_status_t stat,
    output canrxq_pkg::res_t       res
);
    import canrxq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]     count_reg, count_next;
    logic [PTR_W+3:0]     count_wide;
    logic [DLC_W-1:0]     dlc_raw;
    header_t              hdr_wr, hdr_rd;
    logic [HEADER_W-1:0]  hdr_q;
    logic [PAYLOAD_W-1:0] pld_wr, pld_q;
    res_t                 res_reg, res_next;

    // descriptor decode
    always_comb
    begin
        dlc_raw    = cmd.desc_word1[DLC_W-1:0];
        hdr_wr.ext = cmd.desc_word0[EXT_BIT];
        hdr_wr.rtr = cmd.desc_word1[RTR_BIT];
        if (cmd.desc_word0[EXT_BIT])
        begin
            hdr_wr.id = cmd.desc_word0[ID_W-1:0];
        end
        else
        begin
            hdr_wr.id = ID_W'(cmd.desc_word0[STD_ID_MSB:STD_ID_LSB]);
        end
        hdr_wr.dlc = (dlc_raw > MAX_DLC) ? MAX_DLC : dlc_raw;
        pld_wr[PAYLOAD_W-1:WORD_W] = (dlc_raw != '0) ? cmd.desc_data_high : '0;
        pld_wr[WORD_W-1:0]         = (dlc_raw > LOW_MIN_DLC) ? cmd.desc_data_low : '0;
    end

    canrxq_ram #(
        .WIDTH (HEADER_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_header_ram (
        .clk   (clk),
        .we    (ctrl.store),
        .waddr (wr_ptr_reg),
        .wdata (HEADER_W'(hdr_wr)),
        .re    (ctrl.fetch),
        .raddr (rd_ptr_reg),
        .rdata (hdr_q)
    );

    canrxq_ram #(
        .WIDTH (PAYLOAD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_payload_ram (
        .clk   (clk),
        .we    (ctrl.store),
        .waddr (wr_ptr_reg),
        .wdata (pld_wr),
        .re    (ctrl.fetch),
        .raddr (rd_ptr_reg),
        .rdata (pld_q)
    );

    assign hdr_rd = header_t'(hdr_q);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (ctrl.store)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        else if (ctrl.fetch)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
    end

    assign count_wide = {4'b0000, count_next};

    always_comb
    begin
        res_next = res_reg;
        if (ctrl.load_imm)
        begin
            res_next               = '0;
            res_next.status        = ctrl.imm_status;
            res_next.pending_count = count_wide[3:0];
        end
        else if (ctrl.load_pop)
        begin
            res_next.status          = STAT_POP_DELIVERED;
            res_next.frame_id        = hdr_rd.id;
            res_next.frame_extended  = hdr_rd.ext;
            res_next.frame_rtr       = hdr_rd.rtr;
            res_next.frame_dlc       = hdr_rd.dlc;
            res_next.frame_data_high = pld_q[PAYLOAD_W-1:WORD_W];
            res_next.frame_data_low  = pld_q[WORD_W-1:0];
            res_next.pending_count   = count_wide[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign stat.full  = (count_reg == LAST_SLOT);
    assign stat.empty = (count_reg == '0);
    assign res        = res_reg;

endmodule

### src/canrxq_ctrl.sv
// ----------------------------------------------------------------------------
// CAN receive frame queue controller
// Transaction sequencing and result register valid.
// ----------------------------------------------------------------------------
module canrxq_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    input  logic                   opcode,
    input  logic                   res_stall,
    input  canrxq_pkg::dp_status_t stat,
    output logic                   cmd_stall,
    output logic                   res_valid,
    output canrxq_pkg::ctrl_cmd_t  ctrl
);
    import canrxq_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   accept;

    assign out_free = !out_valid_reg || !res_stall;
    assign accept   = cmd_valid && !cmd_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (opcode == OP_POP) && !stat.empty)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl      = '0;
        cmd_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                cmd_stall = !out_free;
                if (cmd_valid && out_free)
                begin
                    if (opcode == OP_PUSH)
                    begin
                        ctrl.load_imm = 1'b1;
                        if (stat.full)
                        begin
                            ctrl.imm_status = STAT_PUSH_DROPPED;
                        end
                        else
                        begin
                            ctrl.store      = 1'b1;
                            ctrl.imm_status = STAT_PUSH_STORED;
                        end
                    end
                    else if (stat.empty)
                    begin
                        ctrl.load_imm   = 1'b1;
                        ctrl.imm_status = STAT_POP_EMPTY;
                    end
                    else
                    begin
                        ctrl.fetch = 1'b1;
                    end
                end
            end
            S_FETCH:
            begin
                ctrl.load_pop = out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    always_comb
    begin
        if (ctrl.load_imm || ctrl.load_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign res_valid = out_valid_reg;

    a_store_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.store |-> !stat.full)
        else $error("store issued into a full ring");

    a_fetch_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.fetch |-> !stat.empty)
        else $error("fetch issued from an empty ring");

    a_fetch_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.fetch |=> cmd_stall)
        else $error("transaction accepted during frame fetch");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.load_imm || ctrl.load_pop) |-> (!out_valid_reg || !res_stall))
        else $error("result overwritten while stalled");

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// CAN receive frame queue testbench
// Pushes receive descriptors and pops frames through the valid/stall channels.
// A scoreboard decodes each accepted transaction into the expected result and
// checks each result in order.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import canrxq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS = 234;

    class frame_queue_scoreboard;
        header_t               frame_hdr[DEPTH];
        logic [PAYLOAD_W-1:0]  frame_data[DEPTH];
        int unsigned           wr_slot;
        int unsigned           rd_slot;
        res_t                  expected_results[$];
        int                    errors;

        function new();
            wr_slot = 0;
            rd_slot = 0;
            errors  = 0;
        endfunction

        function void note_command(cmd_t c);
            res_t              r;
            header_t           h;
            logic [DLC_W-1:0]  dlc;
            logic [WORD_W-1:0] hi;
            logic [WORD_W-1:0] lo;
            int unsigned       nxt;
            r = '0;
            if (c.opcode == OP_PUSH)
            begin
                nxt = (wr_slot + 1) % DEPTH;
                if (nxt == rd_slot)
                begin
                    r.status = STAT_PUSH_DROPPED;
                end
                else
                begin
                    h.ext = c.desc_word0[EXT_BIT];
                    h.id  = h.ext ? c.desc_word0[ID_W-1:0]
                                  : {18'd0, c.desc_word0[STD_ID_MSB:STD_ID_LSB]};
                    h.rtr = c.desc_word1[RTR_BIT];
                    dlc   = c.desc_word1[DLC_W-1:0];
                    hi    = (dlc != '0) ? c.desc_data_high : '0;
                    lo    = (dlc > LOW_MIN_DLC) ? c.desc_data_low : '0;
                    h.dlc = (dlc > MAX_DLC) ? MAX_DLC : dlc;
                    frame_hdr[wr_slot]  = h;
                    frame_data[wr_slot] = {hi, lo};
                    wr_slot  = nxt;
                    r.status = STAT_PUSH_STORED;
                end
            end
            else
            begin
                if (rd_slot == wr_slot)
                begin
                    r.status = STAT_POP_EMPTY;
                end
                else
                begin
                    h = frame_hdr[rd_slot];
                    r.status          = STAT_POP_DELIVERED;
                    r.frame_id        = h.id;
                    r.frame_extended  = h.ext;
                    r.frame_rtr       = h.rtr;
                    r.frame_dlc       = h.dlc;
                    r.frame_data_high = frame_data[rd_slot][PAYLOAD_W-1:WORD_W];
                    r.frame_data_low  = frame_data[rd_slot][WORD_W-1:0];
                    rd_slot = (rd_slot + 1) % DEPTH;
                end
            end
            r.pending_count = 4'((wr_slot + DEPTH - rd_slot) % DEPTH);
            expected_results.push_back(r);
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_results.size() == 0)
            begin
                $error("result with no transaction outstanding: %h", got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.frame_id !== want.frame_id)
            begin
                $error("frame_id: expected %h, actual %h", want.frame_id, got.frame_id);
                errors++;
            end
            if (got.frame_extended !== want.frame_extended)
            begin
                $error("frame_extended: expected %b, actual %b",
                       want.frame_extended, got.frame_extended);
                errors++;
            end
            if (got.frame_rtr !== want.frame_rtr)
            begin
                $error("frame_rtr: expected %b, actual %b", want.frame_rtr, got.frame_rtr);
                errors++;
            end
            if (got.frame_dlc !== want.frame_dlc)
            begin
                $error("frame_dlc: expected %0d, actual %0d", want.frame_dlc, got.frame_dlc);
                errors++;
            end
            if (got.frame_data_high !== want.frame_data_high)
            begin
                $error("frame_data_high: expected %h, actual %h",
                       want.frame_data_high, got.frame_data_high);
                errors++;
            end
            if (got.frame_data_low !== want.frame_data_low)
            begin
                $error("frame_data_low: expected %h, actual %h",
                       want.frame_data_low, got.frame_data_low);
                errors++;
            end
            if (got.pending_count !== want.pending_count)
            begin
                $error("pending_count: expected %0d, actual %0d",
                       want.pending_count, got.pending_count);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic res_valid;
    logic res_stall;
    res_t res;

    frame_queue_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_req;
    int hold_ack;
    int hold_left;
    int cycle_count;

    can_rx_descriptor_frame_queue_core #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            sb.check_result(res);
        end
    end

    // receiver back-pressure; a long hold-off is served when requested
    always @(negedge clk)
    begin
        if (hold_left == 0 && hold_req != hold_ack)
        begin
            hold_left = HOLD_CYCLES;
            hold_ack  = hold_req;
        end
        if (hold_left > 0)
        begin
            res_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            res_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic cmd_t push_item(logic [31:0] w0, logic [31:0] w1,
                                       logic [31:0] dhi, logic [31:0] dlo);
        cmd_t c;
        c.opcode         = OP_PUSH;
        c.desc_word0     = w0;
        c.desc_word1     = w1;
        c.desc_data_high = dhi;
        c.desc_data_low  = dlo;
        return c;
    endfunction

    function automatic cmd_t pop_item();
        cmd_t c;
        c.opcode         = OP_POP;
        c.desc_word0     = $urandom;
        c.desc_word1     = $urandom;
        c.desc_data_high = $urandom;
        c.desc_data_low  = $urandom;
        return c;
    endfunction

    task automatic send_command(input cmd_t c);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (cmd_stall);
        sb.note_command(c);
    endtask

    task automatic send_random_bursts(input int count);
        int push_pct;
        int burst;
        int i;
        i = 0;
        while (i < count)
        begin
            case ($urandom_range(2))
                0: push_pct = 85;
                1: push_pct = 15;
                default: push_pct = 50;
            endcase
            burst = $urandom_range(40, 10);
            if (burst > count - i)
            begin
                burst = count - i;
            end
            repeat (burst)
            begin
                if ($urandom_range(99) < push_pct)
                    send_command(push_item($urandom, $urandom, $urandom, $urandom));
                else
                    send_command(pop_item());
                i++;
            end
        end
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        cmd           = '0;
        res_stall     = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 0;
        hold_ack      = 0;
        hold_left     = 0;
        cycle_count   = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty pop, identifier and length extremes, drain
        send_command(pop_item());
        send_command(push_item(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_command(push_item(32'h7FFF_FFFF, 32'h0000_0014, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_command(push_item(32'hFFFF_FFFF, 32'h0000_0005, 32'h0123_4567, 32'h89AB_CDEF));
        send_command(push_item(32'h8000_0000, 32'h0000_0008, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_command(push_item(32'h1FFC_0000, 32'h0000_0009, 32'hA5A5_A5A5, 32'h5A5A_5A5A));
        send_command(push_item(32'h9FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_command(push_item(32'h6003_FFFF, 32'hFFFF_FFE1, 32'hDEAD_BEEF, 32'hCAFE_F00D));
        send_command(push_item(32'hE000_0000, 32'h0000_001F, 32'h0000_0000, 32'h0000_0000));
        repeat (8) send_command(pop_item());
        send_command(pop_item());

        send_idle_pct = 29;
        recv_idle_pct = 47;
        send_random_bursts(PHASE_ITEMS);

        send_idle_pct = 47;
        recv_idle_pct = 29;
        send_random_bursts(PHASE_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req++;
        repeat (30) send_command(push_item($urandom, $urandom, $urandom, $urandom));
        send_random_bursts(PHASE_ITEMS);

        @(negedge clk);
        cmd_valid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

### sim.f
src/canrxq_pkg.sv
src/canrxq_ram.sv
src/canrxq_datapath.sv
src/canrxq_ctrl.sv
src/can_rx_descriptor_frame_queue_core.sv
verif/testbench.sv
